[rtl/lzsswd_pkg.sv]
package lzsswd_pkg;

	// default geometry
	localparam int WINDOW_BITS_DEF = 8;
	localparam int LENGTH_BITS_DEF = 4;
	localparam int COUNT_BITS_DEF  = 24;

	// fixed field widths
	localparam int CFG_W  = 24;
	localparam int BYTE_W = 8;
	localparam int ACT_W  = 2;

	// action codes carried on tuser
	localparam logic [ACT_W-1:0] ACT_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BYTE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_KEY   = 2'd2;

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LIT,
		PH_POS,
		PH_LEN
	} phase_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_BIT,
		ST_COPY_RD,
		ST_COPY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic clr_step;
		logic key_wr;
		logic key_rd;
		logic load_byte;
		logic bit_step;
		logic deactivate;
		logic copy_rd;
		logic copy_emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic active;
		logic at_limit;
		logic lit_due;
		logic len_due;
		logic last_bit;
		logic bits_zero;
		logic copy_end;
		logic emit_last;
		logic out_free;
		logic clr_last;
	} dp_sts_t;

endpackage

[rtl/lzsswd_ctrl.sv]
module lzsswd_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [lzsswd_pkg::ACT_W-1:0]        in_action,
	output logic                                in_ready,
	input  lzsswd_pkg::dp_sts_t                 sts,
	output lzsswd_pkg::dp_cmd_t                 cmd
);

	lzsswd_pkg::state_t state_q;
	lzsswd_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsswd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lzsswd_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = lzsswd_pkg::ST_IDLE;
				end
			end
			lzsswd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_action == lzsswd_pkg::ACT_START) begin
						state_nxt = lzsswd_pkg::ST_CLEAR;
					end else if (in_action == lzsswd_pkg::ACT_BYTE && sts.active) begin
						state_nxt = lzsswd_pkg::ST_KEY;
					end
				end
			end
			lzsswd_pkg::ST_KEY: begin
				state_nxt = lzsswd_pkg::ST_BIT;
			end
			lzsswd_pkg::ST_BIT: begin
				priority if (sts.at_limit) begin
					state_nxt = lzsswd_pkg::ST_IDLE;
				end else if (sts.lit_due && !sts.out_free) begin
					state_nxt = lzsswd_pkg::ST_BIT;
				end else if (sts.len_due) begin
					state_nxt = lzsswd_pkg::ST_COPY_RD;
				end else if (sts.last_bit) begin
					state_nxt = lzsswd_pkg::ST_IDLE;
				end else begin
					state_nxt = lzsswd_pkg::ST_BIT;
				end
			end
			lzsswd_pkg::ST_COPY_RD: begin
				state_nxt = lzsswd_pkg::ST_COPY;
			end
			lzsswd_pkg::ST_COPY: begin
				if (sts.out_free && (sts.copy_end || sts.emit_last)) begin
					state_nxt = sts.bits_zero ? lzsswd_pkg::ST_IDLE : lzsswd_pkg::ST_BIT;
				end
			end
			default: begin
				state_nxt = lzsswd_pkg::ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lzsswd_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			lzsswd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_action)
						lzsswd_pkg::ACT_START: cmd.start  = 1'b1;
						lzsswd_pkg::ACT_KEY:   cmd.key_wr = 1'b1;
						lzsswd_pkg::ACT_BYTE:  cmd.key_rd = sts.active;
						default:               cmd.start  = 1'b0;
					endcase
				end
			end
			lzsswd_pkg::ST_KEY: begin
				cmd.load_byte = 1'b1;
			end
			lzsswd_pkg::ST_BIT: begin
				priority if (sts.at_limit) begin
					cmd.deactivate = 1'b1;
				end else if (!sts.lit_due || sts.out_free) begin
					cmd.bit_step = 1'b1;
				end else begin
					// literal waits for the output register
					cmd.bit_step = 1'b0;
				end
			end
			lzsswd_pkg::ST_COPY_RD: begin
				cmd.copy_rd = 1'b1;
			end
			lzsswd_pkg::ST_COPY: begin
				cmd.copy_emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/lzsswd_dp.sv]
module lzsswd_dp #(
	parameter int WINDOW_BITS = lzsswd_pkg::WINDOW_BITS_DEF,
	parameter int LENGTH_BITS = lzsswd_pkg::LENGTH_BITS_DEF,
	parameter int COUNT_BITS  = lzsswd_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lzsswd_pkg::dp_cmd_t                 cmd,
	output lzsswd_pkg::dp_sts_t                 sts,
	input  logic                                cfg_valid,
	input  logic [lzsswd_pkg::CFG_W-1:0]        cfg_data,
	input  logic [lzsswd_pkg::BYTE_W-1:0]       in_data_byte,
	input  logic [lzsswd_pkg::BYTE_W-1:0]       in_key_index,
	input  logic [lzsswd_pkg::BYTE_W-1:0]       in_key_value,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lzsswd_pkg::BYTE_W-1:0]       m_tdata,
	output logic                                m_tlast
);

	localparam int WIN_SIZE = 1 << WINDOW_BITS;
	localparam int ACC_W    = (WINDOW_BITS > 8) ? WINDOW_BITS : 8;
	localparam int FCNT_W   = $clog2(ACC_W + 1);
	localparam int REM_W    = LENGTH_BITS + 1;
	localparam int KEY_SIZE = 1 << lzsswd_pkg::BYTE_W;
	localparam logic [WINDOW_BITS-1:0] START_POS =
		WINDOW_BITS'(WIN_SIZE - (1 << LENGTH_BITS) - 1);
	localparam logic [FCNT_W-1:0] LIT_END = FCNT_W'(lzsswd_pkg::BYTE_W - 1);
	localparam logic [FCNT_W-1:0] POS_END = FCNT_W'(WINDOW_BITS - 1);
	localparam logic [FCNT_W-1:0] LEN_END = FCNT_W'(LENGTH_BITS - 1);

	// memories
	logic [lzsswd_pkg::BYTE_W-1:0] key_mem [KEY_SIZE];
	logic [lzsswd_pkg::BYTE_W-1:0] win_mem [WIN_SIZE];

	logic [COUNT_BITS-1:0]         len_q;
	logic [KEY_SIZE-1:0]           key_vld_q;
	logic [lzsswd_pkg::BYTE_W-1:0] key_rd_q;
	logic [lzsswd_pkg::BYTE_W-1:0] key_idx_q;
	logic [lzsswd_pkg::BYTE_W-1:0] shift_q;
	logic [3:0]                    bitcnt_q;
	lzsswd_pkg::phase_t            phase_q;
	logic [ACC_W-1:0]              acc_q;
	logic [FCNT_W-1:0]             fcnt_q;
	logic [WINDOW_BITS-1:0]        mpos_q;
	logic [WINDOW_BITS-1:0]        rd_ptr_q;
	logic [REM_W-1:0]              rem_q;
	logic [COUNT_BITS-1:0]         produced_q;
	logic                          active_q;
	logic [WINDOW_BITS-1:0]        wp_q;
	logic [WINDOW_BITS-1:0]        clr_cnt_q;
	logic [lzsswd_pkg::BYTE_W-1:0] win_rd_q;
	logic                          fwd_q;
	logic [lzsswd_pkg::BYTE_W-1:0] fwd_byte_q;
	logic                          out_vld_q;
	logic [lzsswd_pkg::BYTE_W-1:0] out_byte_q;
	logic                          out_last_q;

	logic                          bit_in;
	logic [ACC_W-1:0]              acc_new;
	logic                          lit_due;
	logic                          pos_due;
	logic                          len_due;
	logic [lzsswd_pkg::BYTE_W-1:0] copy_byte;
	logic                          emit;
	logic [lzsswd_pkg::BYTE_W-1:0] emit_byte;
	logic [COUNT_BITS-1:0]         prod_next;
	logic                          emit_last;
	logic                          out_free;
	logic                          win_we;
	logic [WINDOW_BITS-1:0]        win_waddr;
	logic [lzsswd_pkg::BYTE_W-1:0] win_wdata;
	logic                          win_re;
	logic [WINDOW_BITS-1:0]        win_raddr;

	assign bit_in    = shift_q[lzsswd_pkg::BYTE_W-1];
	assign acc_new   = {acc_q[ACC_W-2:0], bit_in};
	assign lit_due   = (phase_q == lzsswd_pkg::PH_LIT) && (fcnt_q == LIT_END);
	assign pos_due   = (phase_q == lzsswd_pkg::PH_POS) && (fcnt_q == POS_END);
	assign len_due   = (phase_q == lzsswd_pkg::PH_LEN) && (fcnt_q == LEN_END);
	// a byte written in the cycle of its read comes from the bypass
	assign copy_byte = fwd_q ? fwd_byte_q : win_rd_q;
	assign emit      = (cmd.bit_step && lit_due) || cmd.copy_emit;
	assign emit_byte = cmd.copy_emit ? copy_byte : acc_new[lzsswd_pkg::BYTE_W-1:0];
	assign prod_next = produced_q + 1'b1;
	assign emit_last = (prod_next == len_q);
	assign out_free  = !out_vld_q || m_tready;

	assign win_we    = cmd.clr_step || emit;
	assign win_waddr = cmd.clr_step ? clr_cnt_q : wp_q;
	assign win_wdata = cmd.clr_step ? '0 : emit_byte;
	assign win_re    = cmd.copy_rd || cmd.copy_emit;
	assign win_raddr = cmd.copy_rd ? mpos_q : rd_ptr_q;

	always_comb begin
		sts           = '0;
		sts.active    = active_q;
		sts.at_limit  = !active_q || (produced_q >= len_q);
		sts.lit_due   = lit_due;
		sts.len_due   = len_due;
		sts.last_bit  = (bitcnt_q == 4'd1);
		sts.bits_zero = (bitcnt_q == 4'd0);
		sts.copy_end  = (rem_q == '0);
		sts.emit_last = emit_last;
		sts.out_free  = out_free;
		sts.clr_last  = (clr_cnt_q == '1);
	end

	// key map, identity until an entry is written
	always_ff @(posedge clk) begin
		if (cmd.key_wr) begin
			key_mem[in_key_index] <= in_key_value;
		end
		if (cmd.key_rd) begin
			key_rd_q  <= key_mem[in_data_byte];
			key_idx_q <= in_data_byte;
		end
	end

	// history window
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= win_wdata;
		end
		if (win_re) begin
			win_rd_q   <= win_mem[win_raddr];
			fwd_q      <= win_we && (win_raddr == win_waddr);
			fwd_byte_q <= win_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			key_vld_q  <= '0;
			shift_q    <= '0;
			bitcnt_q   <= '0;
			phase_q    <= lzsswd_pkg::PH_FLAG;
			acc_q      <= '0;
			fcnt_q     <= '0;
			mpos_q     <= '0;
			rd_ptr_q   <= '0;
			rem_q      <= '0;
			produced_q <= '0;
			active_q   <= 1'b0;
			wp_q       <= START_POS;
			clr_cnt_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q <= COUNT_BITS'(cfg_data);
			end
			if (cmd.key_wr) begin
				key_vld_q[in_key_index] <= 1'b1;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.start) begin
				wp_q       <= START_POS;
				bitcnt_q   <= '0;
				phase_q    <= lzsswd_pkg::PH_FLAG;
				acc_q      <= '0;
				fcnt_q     <= '0;
				mpos_q     <= '0;
				produced_q <= '0;
				active_q   <= (len_q != '0);
			end
			if (cmd.deactivate) begin
				active_q <= 1'b0;
			end
			if (cmd.load_byte) begin
				shift_q  <= key_vld_q[key_idx_q] ? key_rd_q : key_idx_q;
				bitcnt_q <= 4'd8;
			end
			if (cmd.bit_step) begin
				shift_q  <= {shift_q[lzsswd_pkg::BYTE_W-2:0], 1'b0};
				bitcnt_q <= bitcnt_q - 1'b1;
				unique case (phase_q)
					lzsswd_pkg::PH_FLAG: begin
						phase_q <= bit_in ? lzsswd_pkg::PH_LIT : lzsswd_pkg::PH_POS;
						acc_q   <= '0;
						fcnt_q  <= '0;
					end
					lzsswd_pkg::PH_LIT: begin
						acc_q  <= acc_new;
						fcnt_q <= fcnt_q + 1'b1;
						if (lit_due) begin
							phase_q <= lzsswd_pkg::PH_FLAG;
						end
					end
					lzsswd_pkg::PH_POS: begin
						if (pos_due) begin
							mpos_q  <= acc_new[WINDOW_BITS-1:0];
							acc_q   <= '0;
							fcnt_q  <= '0;
							phase_q <= lzsswd_pkg::PH_LEN;
						end else begin
							acc_q  <= acc_new;
							fcnt_q <= fcnt_q + 1'b1;
						end
					end
					lzsswd_pkg::PH_LEN: begin
						if (len_due) begin
							// bytes left after the first one: length + 1
							rem_q   <= REM_W'(acc_new[LENGTH_BITS-1:0]) + 1'b1;
							phase_q <= lzsswd_pkg::PH_FLAG;
						end else begin
							acc_q  <= acc_new;
							fcnt_q <= fcnt_q + 1'b1;
						end
					end
					default: begin
						phase_q <= lzsswd_pkg::PH_FLAG;
					end
				endcase
			end
			if (cmd.copy_rd) begin
				rd_ptr_q <= mpos_q + 1'b1;
			end
			if (cmd.copy_emit) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				rem_q    <= rem_q - 1'b1;
			end
			if (emit) begin
				wp_q       <= wp_q + 1'b1;
				produced_q <= prod_next;
				if (emit_last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

[rtl/lzsswd_core.sv]
// input beats: a key write or start is taken from idle; a byte beat goes through key lookup
// and its bit walk, then a copy read and length + 2 copied bytes per match token it completes
// throughput is bounded by the single window write port: one output byte per cycle at best
// output beats appear in the cycle after the byte is produced, from an output register
// reset (arst_n low) and each start beat run a clearing pass that zeroes every entry of
// the history window, with s_tready low; the key map returns to identity on reset only
module lzss_window_decompressor_core #(
	parameter int WINDOW_BITS = lzsswd_pkg::WINDOW_BITS_DEF,
	parameter int LENGTH_BITS = lzsswd_pkg::LENGTH_BITS_DEF,
	parameter int COUNT_BITS  = lzsswd_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// compressed side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [3*lzsswd_pkg::BYTE_W-1:0]     s_tdata,   // data_byte, key_index, key_value
	input  logic [lzsswd_pkg::ACT_W-1:0]        s_tuser,   // action
	// decompressed side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lzsswd_pkg::BYTE_W-1:0]       m_tdata,   // out_byte
	output logic                                m_tlast,   // is_last
	// output length register
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lzsswd_pkg::CFG_W-1:0]        cfg_data   // output_length
);

	lzsswd_pkg::dp_cmd_t cmd;
	lzsswd_pkg::dp_sts_t sts;

	// the length register takes a beat in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: clear pass, key lookup, bit walk, match copy
	lzsswd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_action(s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// key map, history window, bit reader, counters and output register
	lzsswd_dp #(
		.WINDOW_BITS(WINDOW_BITS),
		.LENGTH_BITS(LENGTH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.in_data_byte(s_tdata[lzsswd_pkg::BYTE_W-1:0]),
		.in_key_index(s_tdata[2*lzsswd_pkg::BYTE_W-1:lzsswd_pkg::BYTE_W]),
		.in_key_value(s_tdata[3*lzsswd_pkg::BYTE_W-1:2*lzsswd_pkg::BYTE_W]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

[verif/lzsswd_checker.sv]
module lzsswd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [3*lzsswd_pkg::BYTE_W-1:0]  s_tdata,   // data_byte, key_index, key_value
	input  logic [lzsswd_pkg::ACT_W-1:0]     s_tuser,   // action
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [lzsswd_pkg::BYTE_W-1:0]    m_tdata,   // out_byte
	input  logic                             m_tlast,   // is_last
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lzsswd_pkg::CFG_W-1:0]     cfg_data,  // output_length
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_BITS = lzsswd_pkg::WINDOW_BITS_DEF;
	localparam int WIN_SIZE = 1 << WIN_BITS;
	localparam logic [WIN_BITS-1:0] START_POS =
		WIN_BITS'(WIN_SIZE - ((1 << lzsswd_pkg::LENGTH_BITS_DEF) + 1));

	typedef struct packed {
		logic [lzsswd_pkg::BYTE_W-1:0] data;
		logic                          last;
	} out_beat_t;

	logic [lzsswd_pkg::BYTE_W-1:0]         window [WIN_SIZE];
	logic [lzsswd_pkg::BYTE_W-1:0]         subst [256];
	logic [WIN_BITS-1:0]                   wr_pos;
	logic [WIN_BITS-1:0]                   copy_pos;
	lzsswd_pkg::phase_t                    phase;
	int unsigned                           field;
	int unsigned                           field_cnt;
	logic [lzsswd_pkg::COUNT_BITS_DEF-1:0] produced;
	logic [lzsswd_pkg::COUNT_BITS_DEF-1:0] out_len;
	bit                                    active;
	out_beat_t                             expected_beats [$];
	out_beat_t                             want;
	int                                    beat_errs;

	task automatic restart_stream();
		foreach (window[i])
			window[i] = '0;
		wr_pos    = START_POS;
		phase     = lzsswd_pkg::PH_FLAG;
		field     = 0;
		field_cnt = 0;
		copy_pos  = '0;
		produced  = '0;
		active    = (out_len != '0);
	endtask

	// one decoded byte into the window and the expected stream
	task automatic push_byte(input logic [lzsswd_pkg::BYTE_W-1:0] c);
		if (!active || produced >= out_len) begin
			active = 1'b0;
			return;
		end
		window[wr_pos] = c;
		wr_pos         = wr_pos + 1'b1;
		produced       = produced + 1'b1;
		expected_beats.push_back('{data: c, last: (produced == out_len)});
		if (produced == out_len)
			active = 1'b0;
	endtask

	task automatic shift_in_bit(input logic b);
		int unsigned copy_len;
		int unsigned k;
		if (phase == lzsswd_pkg::PH_FLAG) begin
			phase     = b ? lzsswd_pkg::PH_LIT : lzsswd_pkg::PH_POS;
			field     = 0;
			field_cnt = 0;
			return;
		end
		field     = (field << 1) | b;
		field_cnt = field_cnt + 1;
		case (phase)
			lzsswd_pkg::PH_LIT: begin
				if (field_cnt == 8) begin
					push_byte(field[7:0]);
					phase = lzsswd_pkg::PH_FLAG;
				end
			end
			lzsswd_pkg::PH_POS: begin
				if (field_cnt == WIN_BITS) begin
					copy_pos  = field[WIN_BITS-1:0];
					field     = 0;
					field_cnt = 0;
					phase     = lzsswd_pkg::PH_LEN;
				end
			end
			default: begin
				if (field_cnt == lzsswd_pkg::LENGTH_BITS_DEF) begin
					copy_len = field + 2;
					for (k = 0; k < copy_len && active; k++)
						push_byte(window[copy_pos + WIN_BITS'(k)]);
					phase = lzsswd_pkg::PH_FLAG;
				end
			end
		endcase
	endtask

	task automatic feed_byte(input logic [lzsswd_pkg::BYTE_W-1:0] raw);
		logic [lzsswd_pkg::BYTE_W-1:0] sh;
		int n;
		if (!active)
			return;
		sh = subst[raw];
		for (n = 0; n < 8; n++) begin
			if (produced >= out_len)
				active = 1'b0;
			if (!active)
				break;
			shift_in_bit(sh[7]);
			sh = sh << 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len = '0;
			foreach (subst[i])
				subst[i] = 8'(i);
			restart_stream();
			active = 1'b0;
			expected_beats.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			beat_errs = 0;
			if (cfg_valid && cfg_ready)
				out_len = cfg_data;
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					lzsswd_pkg::ACT_START: restart_stream();
					lzsswd_pkg::ACT_BYTE:  feed_byte(s_tdata[7:0]);
					lzsswd_pkg::ACT_KEY:   subst[s_tdata[15:8]] = s_tdata[23:16];
					default:               ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					$error("out_byte: no beat expected, got %02h", m_tdata);
					beat_errs++;
				end else begin
					want = expected_beats.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
						beat_errs++;
					end
					if (m_tlast !== want.last) begin
						$error("is_last: expected %0b, got %0b", want.last, m_tlast);
						beat_errs++;
					end
				end
			end
			fail_count <= fail_count + beat_errs;
			pending    <= expected_beats.size();
		end
	end

endmodule

[verif/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYC     = 300;   // longest internal work: clearing pass plus a long copy
	localparam int WATCHDOG_LIMIT = 5000;  // cycles without any beat on any channel
	localparam int RAND_ITEMS     = 350;
	localparam int LEN_W          = lzsswd_pkg::CFG_W;
	localparam logic [lzsswd_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [7:0] STREAM_START_POS = 8'd239;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [3*lzsswd_pkg::BYTE_W-1:0] s_tdata   = '0;
	logic [lzsswd_pkg::ACT_W-1:0]    s_tuser   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [lzsswd_pkg::BYTE_W-1:0]   m_tdata;
	logic                            m_tlast;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [LEN_W-1:0]                cfg_data  = '0;
	int                              fail_count;
	int                              pending;

	// stimulus side view of the key map, used to pick raw bytes that decode to chosen bits
	logic [7:0] gen_key [256];
	bit         tok_bits [$];
	logic [7:0] gen_wr;
	int         n_items;
	bit         no_idle;
	int         rx_stall;
	int         idle_cycles;

	lzss_window_decompressor_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lzsswd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
		end else if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			rx_stall <= pick_gap() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// a hung handshake ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one beat on the compressed side; valid stays high so back-to-back beats have no gap,
	// every other task that lets time pass drops it first
	task automatic send_item(input logic [lzsswd_pkg::ACT_W-1:0] act, input logic [7:0] d,
	                         input logic [7:0] ki, input logic [7:0] kv, input bit counted);
		int gap;
		gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {kv, ki, d};
		do @(posedge clk); while (!s_tready);
		if (counted)
			n_items++;
	endtask

	// wait until every expected beat is out, then let the block finish internal work
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic open_stream(input logic [LEN_W-1:0] len);
		settle();
		write_len(len);
		send_item(lzsswd_pkg::ACT_START, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		tok_bits.delete();
		gen_wr = STREAM_START_POS;
	endtask

	// raw byte whose key map entry gives v, if one exists
	function automatic logic [7:0] raw_for(input logic [7:0] v);
		int base;
		logic [7:0] idx;
		base = $urandom_range(0, 255);
		for (int i = 0; i < 256; i++) begin
			idx = 8'(base + i);
			if (gen_key[idx] == v)
				return idx;
		end
		return v;
	endfunction

	task automatic put_bits(input int unsigned value, input int n);
		for (int i = n - 1; i >= 0; i--)
			tok_bits.push_back(value[i]);
	endtask

	task automatic drain_bits();
		logic [7:0] b;
		b = '0;
		while (tok_bits.size() >= 8) begin
			for (int i = 0; i < 8; i++)
				b = {b[6:0], tok_bits.pop_front()};
			send_item(lzsswd_pkg::ACT_BYTE, raw_for(b), 8'($urandom), 8'($urandom), 1'b1);
		end
	endtask

	task automatic put_literal(input logic [7:0] v);
		put_bits(1, 1);
		put_bits(32'(v), 8);
		gen_wr = gen_wr + 1'b1;
		drain_bits();
	endtask

	task automatic put_match(input logic [7:0] pos, input logic [3:0] len);
		put_bits(0, 1);
		put_bits(32'(pos), 8);
		put_bits(32'(len), 4);
		gen_wr = gen_wr + 8'(len) + 8'd2;
		drain_bits();
	endtask

	// pad the last byte with random bits, a partial token
	task automatic close_bits();
		while (tok_bits.size() % 8 != 0)
			tok_bits.push_back(1'($urandom));
		drain_bits();
	endtask

	task automatic swap_keys(input logic [7:0] i, input logic [7:0] j);
		logic [7:0] vi;
		logic [7:0] vj;
		vi = gen_key[i];
		vj = gen_key[j];
		gen_key[i] = vj;
		gen_key[j] = vi;
		send_item(lzsswd_pkg::ACT_KEY, 8'($urandom), i, vj, 1'b1);
		send_item(lzsswd_pkg::ACT_KEY, 8'($urandom), j, vi, 1'b1);
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		int ntok;
		int pick;

		foreach (gen_key[i])
			gen_key[i] = 8'(i);
		n_items = 0;
		no_idle = 1'b0;
		gen_wr  = STREAM_START_POS;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// no stream yet: byte is dropped, unused action code too
		send_item(lzsswd_pkg::ACT_BYTE, 8'hFF, 8'h00, 8'hFF, 1'b0);
		send_item(ACT_UNUSED, 8'h00, 8'hFF, 8'h00, 1'b0);

		// zero length: start leaves the stream inactive
		open_stream('0);
		send_item(lzsswd_pkg::ACT_BYTE, 8'h00, 8'h00, 8'h00, 1'b0);

		// longest length, key entries at both ends swapped mid-stream, raw edge bytes
		open_stream({LEN_W{1'b1}});
		send_item(lzsswd_pkg::ACT_BYTE, 8'h80, 8'h00, 8'h00, 1'b1);
		swap_keys(8'h00, 8'hFF);
		send_item(lzsswd_pkg::ACT_BYTE, 8'h00, 8'hFF, 8'hFF, 1'b1);
		send_item(lzsswd_pkg::ACT_BYTE, 8'hFF, 8'h00, 8'h00, 1'b1);
		send_item(lzsswd_pkg::ACT_BYTE, 8'h01, 8'h5A, 8'hA5, 1'b1);
		send_item(lzsswd_pkg::ACT_BYTE, 8'h5A, 8'hA5, 8'h5A, 1'b1);

		// overlapping longest copy cut by the length, rest of the byte dropped
		open_stream(24'd10);
		put_literal(8'h00);
		put_literal(8'hFF);
		put_match(gen_wr - 8'd2, 4'hF);
		close_bits();
		send_item(lzsswd_pkg::ACT_BYTE, 8'($urandom), 8'h00, 8'h00, 1'b0);

		// length of one
		open_stream(24'd1);
		put_literal(8'hA5);
		close_bits();

		// length lowered below what was already produced: no last marker
		open_stream(24'd300);
		repeat (3) put_literal(8'($urandom));
		close_bits();
		settle();
		write_len(24'd1);
		put_literal(8'h3C);
		close_bits();

		// ---- random part ----
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 19))
				0:       len = '0;
				1:       len = {LEN_W{1'b1}};
				2:       len = LEN_W'($urandom_range(1, 4));
				default: len = LEN_W'($urandom_range(5, 160));
			endcase
			open_stream(len);
			ntok = $urandom_range(3, 30);
			repeat (ntok) begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					swap_keys(8'($urandom), 8'($urandom));
				else if (pick == 1)  // stray byte, shifts token alignment
					send_item(lzsswd_pkg::ACT_BYTE, 8'($urandom), 8'($urandom),
					          8'($urandom), 1'b1);
				else if (pick < 7)
					put_literal(8'($urandom));
				else if (pick < 14)  // copy from recent history
					put_match(gen_wr - 8'($urandom_range(1, 24)), 4'($urandom));
				else
					put_match(8'($urandom), 4'($urandom));
			end
			close_bits();
			pick = $urandom_range(0, 5);
			if (pick == 0) begin
				// change the length of a running stream
				settle();
				write_len(LEN_W'($urandom_range(0, 8)));
				repeat (2) put_literal(8'($urandom));
				close_bits();
			end else if (pick == 1) begin
				send_item(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
				send_item(lzsswd_pkg::ACT_BYTE, 8'($urandom), 8'($urandom),
				          8'($urandom), 1'b0);
			end
		end

		// drain and verdict
		settle();
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
